// File: rtl/core/mite_pkg.sv
// Shared types and constants for the I-type execute block.
`default_nettype none

package mite_pkg;

    // Data memory depth in words; a power of two so the word index is a bit field.
    localparam int MEM_WORDS = 1024;
    localparam int ADDR_W    = $clog2(MEM_WORDS);
    localparam int DATA_W    = 32;

    typedef enum logic [3:0] {
        K_ADDI  = 4'd0,
        K_ADDIU = 4'd1,
        K_ANDI  = 4'd2,
        K_ORI   = 4'd3,
        K_SLTI  = 4'd4,
        K_SLTIU = 4'd5,
        K_LW    = 4'd6,
        K_SW    = 4'd7,
        K_BEQ   = 4'd8,
        K_BNE   = 4'd9,
        K_LUI   = 4'd10
    } t_kind;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } t_mem_req;

endpackage

`default_nettype wire

// File: rtl/core/mite_dmem.sv
// Data word store with a registered read and a clearing sweep after reset.
`default_nettype none

module mite_dmem
    import mite_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_mem_req          i_req,
    output logic [DATA_W-1:0]      o_rdata,
    output logic                   o_busy
);

    logic [DATA_W-1:0] r_mem [MEM_WORDS];
    logic [ADDR_W-1:0] r_clr_idx;
    logic              r_clearing;

    // Sweep every word to zero, one per cycle, after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == {ADDR_W{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            o_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_busy = r_clearing;

endmodule

`default_nettype wire

// File: rtl/core/mips_i_type_execute_top.sv
// Top level of the MIPS I-type execute block.
// Executes one I-type instruction per input item and returns one result item
// (reg_write, write_value, branch_taken, next_pc) for each.
// Input channel: i_valid / o_stall with the fields i_kind .. i_current_pc;
// an item is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with the result fields as separate ports.
// Pipeline: two register stages. The edge that takes an item starts the data
// memory read and loads the middle stage; the output register loads from the
// middle stage when it can advance, and the result is then on the ports.
// Throughput: one item per cycle while o_stall stays low; lw and sw share the
// single data memory port, which is read and written at the edge that takes
// the item, so a load straight after a store already sees the stored word.
// Reset: i_rst_n is synchronous, active low. Afterwards the memory is swept
// to zero, one word per cycle, over all MEM_WORDS (1024) words; o_stall stays
// high through the sweep.
// Receiver stall: the output register holds its item, the middle stage fills
// behind it, then o_stall rises in the same cycle and items are held upstream.
`default_nettype none

module mips_i_type_execute_top
    import mite_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [3:0]         i_kind,
    input  wire logic [31:0]        i_rs_value,
    input  wire logic [31:0]        i_rt_value,
    input  wire logic signed [15:0] i_immediate,
    input  wire logic [31:0]        i_current_pc,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_reg_write,
    output logic [31:0]             o_write_value,
    output logic                    o_branch_taken,
    output logic [31:0]             o_next_pc
);

    t_mem_req          mem_req;
    logic [DATA_W-1:0] mem_rdata;
    logic              mem_busy;

    logic        in_accept;
    logic        s1_advance;
    logic [31:0] simm;
    logic [31:0] zimm;
    logic [31:0] ea;
    logic [31:0] br_off;
    logic        n_wr;
    logic [31:0] n_val;
    logic        n_load;
    logic        n_taken;
    logic [31:0] n_npc;

    logic        r_s1_valid;
    logic        r_s1_wr;
    logic [31:0] r_s1_val;
    logic        r_s1_load;
    logic        r_s1_taken;
    logic [31:0] r_s1_npc;

    logic        r_out_valid;
    logic        r_out_wr;
    logic [31:0] r_out_val;
    logic        r_out_taken;
    logic [31:0] r_out_npc;

    assign s1_advance = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall    = mem_busy || (r_s1_valid && !s1_advance);
    assign in_accept  = i_valid && !o_stall;

    assign simm   = {{16{i_immediate[15]}}, i_immediate};
    assign zimm   = {16'd0, i_immediate};
    assign ea     = i_rs_value + simm;
    assign br_off = {simm[29:0], 2'b00} - 32'd4;

    always_comb begin
        n_wr    = 1'b0;
        n_val   = '0;
        n_load  = 1'b0;
        n_taken = 1'b0;
        case (t_kind'(i_kind))
            K_ADDI, K_ADDIU: begin
                n_wr  = 1'b1;
                n_val = ea;
            end
            K_ANDI: begin
                n_wr  = 1'b1;
                n_val = i_rs_value & zimm;
            end
            K_ORI: begin
                n_wr  = 1'b1;
                n_val = i_rs_value | zimm;
            end
            K_SLTI: begin
                n_wr  = 1'b1;
                n_val = {31'd0, $signed(i_rs_value) < $signed(simm)};
            end
            K_SLTIU: begin
                n_wr  = 1'b1;
                n_val = {31'd0, i_rs_value < simm};
            end
            K_LW: begin
                n_wr   = 1'b1;
                n_load = 1'b1;
            end
            K_BEQ: begin
                n_taken = (i_rs_value == i_rt_value);
            end
            K_BNE: begin
                n_taken = (i_rs_value != i_rt_value);
            end
            K_LUI: begin
                n_wr  = 1'b1;
                n_val = {i_immediate, 16'd0};
            end
            default: begin
                n_wr = 1'b0;
            end
        endcase
        n_npc = n_taken ? (i_current_pc + br_off) : i_current_pc;
    end

    // Word index drops the byte offset and wraps on the memory depth.
    always_comb begin
        mem_req.we    = in_accept && (t_kind'(i_kind) == K_SW);
        mem_req.re    = in_accept && (t_kind'(i_kind) == K_LW);
        mem_req.addr  = ea[ADDR_W+1:2];
        mem_req.wdata = i_rt_value;
    end

    mite_dmem u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata),
        .o_busy  (mem_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_wr    <= n_wr;
            r_s1_val   <= n_val;
            r_s1_load  <= n_load;
            r_s1_taken <= n_taken;
            r_s1_npc   <= n_npc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Merge the load word in as the item leaves the middle stage.
    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out_wr    <= r_s1_wr;
            r_out_val   <= r_s1_load ? mem_rdata : r_s1_val;
            r_out_taken <= r_s1_taken;
            r_out_npc   <= r_s1_npc;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_reg_write    = r_out_wr;
    assign o_write_value  = r_out_val;
    assign o_branch_taken = r_out_taken;
    assign o_next_pc      = r_out_npc;

    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_busy |-> !in_accept)
        else $error("item accepted during memory clear");

    a_clear_done_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !mem_busy |=> !mem_busy)
        else $error("memory clear restarted without reset");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1_valid)
        else $error("accepted item lost before middle stage");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_advance) |=> (r_s1_valid && $stable(r_s1_val)
            && $stable(r_s1_load)))
        else $error("middle stage changed while held");

    a_mem_idle_unless_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_req.we || mem_req.re) |-> in_accept)
        else $error("memory access without an accepted item");

endmodule

`default_nettype wire
